>>> hdl/fth_pkg.sv
// Shared types, constants and helpers for the FCP-to-file-header converter.
package fth_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int HDR_LEN     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W       = 11;

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    localparam logic [7:0] TAG_FCP   = 8'h62;
    localparam logic [7:0] TAG_FSIZE = 8'h81;
    localparam logic [7:0] TAG_ASIZE = 8'h80;
    localparam logic [7:0] TAG_TYPE  = 8'h82;
    localparam logic [7:0] TAG_ID    = 8'h83;
    localparam logic [7:0] TAG_SEC   = 8'h86;

    localparam logic [7:0] LEN_SHORT = 8'd2;
    localparam logic [7:0] LEN_SEC   = 8'd40;

    localparam logic [4:0] SEC_HEAD_BASE = 5'd17;
    localparam logic [4:0] SEC_TAIL_BASE = 5'd25;

    localparam logic [2:0] SLOT_FSIZE = 3'd0;
    localparam logic [2:0] SLOT_ASIZE = 3'd1;
    localparam logic [2:0] SLOT_TYPE  = 3'd2;
    localparam logic [2:0] SLOT_ID    = 3'd3;
    localparam logic [2:0] SLOT_SEC   = 3'd4;
    localparam logic [2:0] SLOT_NONE  = 3'd5;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_VAL
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_OUTER = 3'd2,
        ST_NO_TYPE   = 3'd3,
        ST_NO_ID     = 3'd4,
        ST_OVERLONG  = 3'd5
    } status_t;

    // One finished run: its status and the masked header image.
    typedef struct packed {
        status_t                    status;
        logic [HDR_LEN-1:0][7:0]    hdr;
    } job_t;

    function automatic logic [2:0] slot_of(input logic [7:0] tag);
        logic [2:0] s;
        unique case (tag)
            TAG_FSIZE: s = SLOT_FSIZE;
            TAG_ASIZE: s = SLOT_ASIZE;
            TAG_TYPE:  s = SLOT_TYPE;
            TAG_ID:    s = SLOT_ID;
            TAG_SEC:   s = SLOT_SEC;
            default:   s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

>>> hdl/fth_front.sv
// Front end: walks the FCP TLVs byte by byte and builds the header image.
module fth_front #(
    parameter int MAX_LEN = fth_pkg::MAX_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output logic            push,
    output fth_pkg::job_t   job
);
    import fth_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       otag_reg, otag_next;
    logic [7:0]       olen_reg, olen_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       ctag_reg, ctag_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       off_reg, off_next;
    logic [4:0]       seen_reg, seen_next;
    logic [4:0]       valid_reg, valid_next;
    logic [2:0]       cap_reg, cap_next;
    logic             ovf_reg, ovf_next;

    logic [HDR_LEN-1:0][7:0] store_reg;
    logic [HDR_LEN-1:0][7:0] hdr_cur;

    logic             wr_en;
    logic [4:0]       wr_addr;
    logic [2:0]       k;
    logic [7:0]       want;
    logic [7:0]       rem_dec;
    logic [7:0]       off_m8;
    logic [CNT_W-1:0] cnt_inc;
    status_t          status;

    assign k       = slot_of(ctag_reg);
    assign want    = (k == SLOT_SEC) ? LEN_SEC : LEN_SHORT;
    assign rem_dec = rem_reg - 8'd1;
    assign off_m8  = off_reg - 8'd8;
    assign cnt_inc = (count_reg == CNT_SAT) ? count_reg : count_reg + 1'b1;

    // header position for the value byte at the current offset
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        if (phase_reg == PH_VAL && count_reg >= CNT_W'(2))
        begin
            case (cap_reg)
                SLOT_FSIZE: begin wr_en = 1'b1; wr_addr = off_reg[0] ? 5'd0 : 5'd1; end
                SLOT_ASIZE: begin wr_en = 1'b1; wr_addr = off_reg[0] ? 5'd2 : 5'd3; end
                SLOT_TYPE:  begin wr_en = 1'b1; wr_addr = off_reg[0] ? 5'd5 : 5'd4; end
                SLOT_ID:    begin wr_en = 1'b1; wr_addr = off_reg[0] ? 5'd6 : 5'd7; end
                SLOT_SEC:
                begin
                    if (off_reg < 8'd8)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = SEC_HEAD_BASE + off_reg[4:0];
                    end
                    else if (off_reg <= 8'd32 && off_reg[1:0] == 2'b00)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = SEC_TAIL_BASE + {2'b00, off_m8[4:2]};
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        otag_next  = otag_reg;
        olen_next  = olen_reg;
        phase_next = phase_reg;
        ctag_next  = ctag_reg;
        rem_next   = rem_reg;
        off_next   = off_reg;
        seen_next  = seen_reg;
        valid_next = valid_reg;
        cap_next   = cap_reg;
        ovf_next   = ovf_reg;

        if (count_reg == '0)
            otag_next = data_byte;
        else if (count_reg == CNT_W'(1))
            olen_next = data_byte;
        else
        begin
            unique case (phase_reg)
                PH_TAG:
                begin
                    ctag_next  = data_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    rem_next = data_byte;
                    off_next = '0;
                    cap_next = SLOT_NONE;
                    if (k != SLOT_NONE && !seen_reg[k])
                    begin
                        seen_next = seen_reg | (5'b1 << k);
                        if (data_byte == want)
                            cap_next = k;
                    end
                    phase_next = (data_byte == 8'd0) ? PH_TAG : PH_VAL;
                end
                PH_VAL:
                begin
                    off_next = off_reg + 8'd1;
                    rem_next = rem_dec;
                    if (rem_dec == 8'd0)
                    begin
                        if (cap_reg != SLOT_NONE)
                            valid_next = valid_reg | (5'b1 << cap_reg);
                        cap_next   = SLOT_NONE;
                        phase_next = PH_TAG;
                    end
                end
                default: phase_next = PH_TAG;
            endcase
        end

        count_next = cnt_inc;
        if (cnt_inc > CNT_W'(MAX_LEN))
            ovf_next = 1'b1;
    end

    // final status, judged on the state after this byte
    always_comb
    begin
        if (ovf_next)
            status = ST_OVERLONG;
        else if (count_next < CNT_W'(HDR_LEN))
            status = ST_SHORT;
        else if (otag_next != TAG_FCP || ({3'b000, olen_next} + CNT_W'(2)) > count_next)
            status = ST_BAD_OUTER;
        else if (!valid_next[SLOT_TYPE])
            status = ST_NO_TYPE;
        else if (!valid_next[SLOT_ID])
            status = ST_NO_ID;
        else
            status = ST_OK;
    end

    always_comb
    begin
        hdr_cur = store_reg;
        if (wr_en)
            hdr_cur[wr_addr] = data_byte;
    end

    // absent tags read as zero, so the store never needs clearing
    always_comb
    begin
        job.status = status;
        for (int i = 0; i < HDR_LEN; i++)
        begin
            if (i < 2)
                job.hdr[i] = valid_next[SLOT_FSIZE] ? hdr_cur[i] : 8'd0;
            else if (i < 4)
                job.hdr[i] = valid_next[SLOT_ASIZE] ? hdr_cur[i] : 8'd0;
            else if (i < 6)
                job.hdr[i] = valid_next[SLOT_TYPE] ? hdr_cur[i] : 8'd0;
            else if (i < 8)
                job.hdr[i] = valid_next[SLOT_ID] ? hdr_cur[i] : 8'd0;
            else if (i < 17)
                job.hdr[i] = 8'd0;
            else
                job.hdr[i] = valid_next[SLOT_SEC] ? hdr_cur[i] : 8'd0;
        end
    end

    assign push = accept && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            otag_reg  <= '0;
            olen_reg  <= '0;
            phase_reg <= PH_TAG;
            ctag_reg  <= '0;
            rem_reg   <= '0;
            off_reg   <= '0;
            seen_reg  <= '0;
            valid_reg <= '0;
            cap_reg   <= SLOT_NONE;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg <= '0;
                otag_reg  <= '0;
                olen_reg  <= '0;
                phase_reg <= PH_TAG;
                ctag_reg  <= '0;
                rem_reg   <= '0;
                off_reg   <= '0;
                seen_reg  <= '0;
                valid_reg <= '0;
                cap_reg   <= SLOT_NONE;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                otag_reg  <= otag_next;
                olen_reg  <= olen_next;
                phase_reg <= phase_next;
                ctag_reg  <= ctag_next;
                rem_reg   <= rem_next;
                off_reg   <= off_next;
                seen_reg  <= seen_next;
                valid_reg <= valid_next;
                cap_reg   <= cap_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
            store_reg[wr_addr] <= data_byte;
    end

endmodule

>>> hdl/fth_queue.sv
// Short job queue between the parser and the header emitter.
module fth_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fth_pkg::job_t   push_job,
    input  logic            pop,
    output fth_pkg::job_t   head,
    output logic            empty,
    output logic            full
);
    import fth_pkg::*;

    job_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = q_reg[rd_ptr_reg];

    // depth is a power of two, so pointers wrap on their own
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> hdl/fth_back.sv
// Back end: plays out one queued job as an error result or 32 header bytes.
module fth_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fth_pkg::job_t   head,
    input  logic            empty,
    output logic            pop,
    output logic [7:0]      out_byte,
    output logic [4:0]      out_index,
    output logic [2:0]      status,
    output logic            last_out,
    output logic            result_valid,
    input  logic            result_stall
);
    import fth_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [4:0] index_reg, index_next;
    logic [2:0] status_reg, status_next;
    logic       last_reg, last_next;
    logic [4:0] emit_reg, emit_next;
    logic       load;
    logic       is_err;

    assign load   = !valid_reg || !result_stall;
    assign is_err = (head.status != ST_OK);
    assign pop    = load && !empty && (is_err || emit_reg == 5'(HDR_LEN - 1));

    always_comb
    begin
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        index_next  = index_reg;
        status_next = status_reg;
        last_next   = last_reg;
        emit_next   = emit_reg;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (is_err)
                begin
                    byte_next   = 8'd0;
                    index_next  = 5'd0;
                    status_next = head.status;
                    last_next   = 1'b1;
                    emit_next   = 5'd0;
                end
                else
                begin
                    byte_next   = head.hdr[emit_reg];
                    index_next  = emit_reg;
                    status_next = ST_OK;
                    last_next   = (emit_reg == 5'(HDR_LEN - 1));
                    emit_next   = emit_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            emit_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        index_reg  <= index_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign out_index    = index_reg;
    assign status       = status_reg;
    assign last_out     = last_reg;

endmodule

>>> hdl/fcp_tlv_to_file_header.sv
// Top level of the FCP-to-file-header converter.
//
// Input channel: one FCP buffer byte per transaction (data_byte), last_byte
// marking the final byte of the buffer. Up to one byte is taken per cycle.
// Output channel: per buffer either one error transaction (status nonzero,
// out_byte and out_index zero, last_out set) or 32 transactions carrying
// header bytes 0..31 in order, status zero, last_out on index 31.
// With the emitter idle, a finished job is written into the job queue at
// the edge that takes the final byte, and from there into the output register.
// Throughput: one byte per cycle in while data_stall is low; one result per
// cycle out while result_stall is low. A finished buffer sits in a two-entry
// job queue while the emitter plays out the previous one, so parsing of the
// next buffer goes on meanwhile. data_stall rises only when both queue
// entries hold unfinished jobs.
// Reset clears the parser, the queue and the output valid flag; no result is
// pending after reset. While result_stall is high a valid result holds steady
// and the parser keeps taking bytes until the queue fills.
module fcp_tlv_to_file_header #(
    parameter int MAX_LEN = fth_pkg::MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       data_valid,
    output logic       data_stall,
    output logic [7:0] out_byte,
    output logic [4:0] out_index,
    output logic [2:0] status,
    output logic       last_out,
    output logic       result_valid,
    input  logic       result_stall
);
    import fth_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    job_t push_job;
    job_t head;

    assign data_stall = full;
    assign accept     = data_valid && !full;

    fth_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .job       (push_job)
    );

    fth_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    fth_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .out_index    (out_index),
        .status       (status),
        .last_out     (last_out),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
